[rtl/core/mahc_pkg.sv]
`timescale 1ns / 1ps
package mahc_pkg;

    localparam int ADDR_W    = 22;
    localparam int MASK_W    = 16;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [MASK_W-1:0] MASK_RESET = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAM_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROM_MASK = 1'b1;

    // operations
    localparam logic [1:0] FUNC_HIT   = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // banks
    localparam logic [1:0] BANK_RAM = 2'd0;
    localparam logic [1:0] BANK_ROM = 2'd1;

    // access kinds
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_EXEC   = 2'd2;
    localparam logic [1:0] KIND_IGNORE = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [1:0]        bank_sel;
        logic [ADDR_W-1:0] phys_addr;
        logic [1:0]        kind;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] read_count;
        logic [OUT_W-1:0] write_count;
        logic [OUT_W-1:0] exec_count;
        logic             cell_valid;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic lookup;
        logic update;
        logic sweep;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_hit;
        logic is_query;
        logic is_clear;
        logic sweep_last;
        logic out_busy;
    } sts_t;

endpackage

[rtl/core/mahc_ram.sv]
`timescale 1ns / 1ps
module mahc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 65536,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/mahc_dp.sv]
`timescale 1ns / 1ps
module mahc_dp #(
    parameter int RAM_CELLS   = 65536,
    parameter int ROM_CELLS   = 65536,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mahc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mahc_pkg::MASK_W-1:0]         cfg_data,
    input  mahc_pkg::in_item_t                  in_data,
    input  logic                                out_stall,
    output logic                                out_valid,
    output mahc_pkg::out_item_t                 out_data,
    input  mahc_pkg::cmd_t                      cmd,
    output mahc_pkg::sts_t                      sts
);

    localparam int RAM_AW    = (RAM_CELLS > 1) ? $clog2(RAM_CELLS) : 1;
    localparam int ROM_AW    = (ROM_CELLS > 1) ? $clog2(ROM_CELLS) : 1;
    localparam int MAX_CELLS = (RAM_CELLS > ROM_CELLS) ? RAM_CELLS : ROM_CELLS;
    localparam int SW        = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int WORD_W    = 3 * COUNT_WIDTH;
    localparam int AW1       = mahc_pkg::ADDR_W + 1;

    localparam logic [AW1-1:0] RAM_LIMIT  = AW1'(RAM_CELLS);
    localparam logic [AW1-1:0] ROM_LIMIT  = AW1'(ROM_CELLS);
    localparam logic [SW:0]    RAM_SWEEP  = (SW + 1)'(RAM_CELLS);
    localparam logic [SW:0]    ROM_SWEEP  = (SW + 1)'(ROM_CELLS);
    localparam logic [SW-1:0]  SWEEP_LAST = SW'(MAX_CELLS - 1);

    logic [mahc_pkg::MASK_W-1:0] ram_mask_reg, ram_mask_next;
    logic [mahc_pkg::MASK_W-1:0] rom_mask_reg, rom_mask_next;
    mahc_pkg::in_item_t          item_reg;
    logic [SW-1:0]               sweep_cnt_reg, sweep_cnt_next;
    logic                        out_valid_reg, out_valid_next;
    mahc_pkg::out_item_t         out_data_reg;

    logic [mahc_pkg::ADDR_W-1:0] ram_cell, rom_cell;
    logic                        ram_ok, rom_ok, loc_ok;
    logic [RAM_AW-1:0]           ram_idx;
    logic [ROM_AW-1:0]           rom_idx;

    logic                        ram_we, rom_we;
    logic [RAM_AW-1:0]           ram_waddr;
    logic [ROM_AW-1:0]           rom_waddr;
    logic [WORD_W-1:0]           ram_rdata, rom_rdata;
    logic [WORD_W-1:0]           word, new_word;

    logic [COUNT_WIDTH-1:0]      rd_cnt, wr_cnt, ex_cnt;
    logic [COUNT_WIDTH-1:0]      rd_inc, wr_inc, ex_inc;
    logic [COUNT_WIDTH+mahc_pkg::OUT_W-1:0] rd_ext, wr_ext, ex_ext;
    logic                        kind_ok, ram_sweep_en, rom_sweep_en;
    mahc_pkg::out_item_t         result;

    // cell lookup from the held transaction
    always_comb
    begin
        ram_cell = item_reg.phys_addr & mahc_pkg::ADDR_W'(ram_mask_reg);
        rom_cell = item_reg.phys_addr & mahc_pkg::ADDR_W'(rom_mask_reg);
        ram_ok   = (item_reg.bank_sel == mahc_pkg::BANK_RAM) && ({1'b0, ram_cell} < RAM_LIMIT);
        rom_ok   = (item_reg.bank_sel == mahc_pkg::BANK_ROM) && ({1'b0, rom_cell} < ROM_LIMIT);
        loc_ok   = ram_ok | rom_ok;
        ram_idx  = ram_cell[RAM_AW-1:0];
        rom_idx  = rom_cell[ROM_AW-1:0];
    end

    // saturating increment of the selected counter
    always_comb
    begin
        word    = (item_reg.bank_sel == mahc_pkg::BANK_ROM) ? rom_rdata : ram_rdata;
        rd_cnt  = word[COUNT_WIDTH-1:0];
        wr_cnt  = word[2*COUNT_WIDTH-1:COUNT_WIDTH];
        ex_cnt  = word[3*COUNT_WIDTH-1:2*COUNT_WIDTH];
        rd_inc  = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);
        wr_inc  = (&wr_cnt) ? wr_cnt : wr_cnt + COUNT_WIDTH'(1);
        ex_inc  = (&ex_cnt) ? ex_cnt : ex_cnt + COUNT_WIDTH'(1);
        kind_ok = item_reg.kind != mahc_pkg::KIND_IGNORE;
        case (item_reg.kind)
            mahc_pkg::KIND_READ:  new_word = {ex_cnt, wr_cnt, rd_inc};
            mahc_pkg::KIND_WRITE: new_word = {ex_cnt, wr_inc, rd_cnt};
            mahc_pkg::KIND_EXEC:  new_word = {ex_inc, wr_cnt, rd_cnt};
            default:              new_word = word;
        endcase
    end

    // query answer: low output bits of each counter
    always_comb
    begin
        rd_ext = {{mahc_pkg::OUT_W{1'b0}}, rd_cnt};
        wr_ext = {{mahc_pkg::OUT_W{1'b0}}, wr_cnt};
        ex_ext = {{mahc_pkg::OUT_W{1'b0}}, ex_cnt};
        if (loc_ok)
        begin
            result.read_count  = rd_ext[mahc_pkg::OUT_W-1:0];
            result.write_count = wr_ext[mahc_pkg::OUT_W-1:0];
            result.exec_count  = ex_ext[mahc_pkg::OUT_W-1:0];
            result.cell_valid  = 1'b1;
        end
        else
        begin
            result = '0;
        end
    end

    // write port: sweep zeros or write back the updated cell
    always_comb
    begin
        ram_sweep_en = {1'b0, sweep_cnt_reg} < RAM_SWEEP;
        rom_sweep_en = {1'b0, sweep_cnt_reg} < ROM_SWEEP;
        if (cmd.sweep)
        begin
            ram_we    = ram_sweep_en;
            rom_we    = rom_sweep_en;
            ram_waddr = sweep_cnt_reg[RAM_AW-1:0];
            rom_waddr = sweep_cnt_reg[ROM_AW-1:0];
        end
        else
        begin
            ram_we    = cmd.update && sts.is_hit && ram_ok && kind_ok;
            rom_we    = cmd.update && sts.is_hit && rom_ok && kind_ok;
            ram_waddr = ram_idx;
            rom_waddr = rom_idx;
        end
    end

    mahc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_CELLS)
    ) u_ram_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.sweep ? '0 : new_word),
        .re    (cmd.lookup),
        .raddr (ram_idx),
        .rdata (ram_rdata)
    );

    mahc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROM_CELLS)
    ) u_rom_store (
        .clk   (clk),
        .we    (rom_we),
        .waddr (rom_waddr),
        .wdata (cmd.sweep ? '0 : new_word),
        .re    (cmd.lookup),
        .raddr (rom_idx),
        .rdata (rom_rdata)
    );

    always_comb
    begin
        ram_mask_next = ram_mask_reg;
        rom_mask_next = rom_mask_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mahc_pkg::REG_RAM_MASK: ram_mask_next = cfg_data;
                mahc_pkg::REG_ROM_MASK: rom_mask_next = cfg_data;
                default:                ;
            endcase
        end
        sweep_cnt_next = cmd.sweep ? sweep_cnt_reg + SW'(1) : '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.update && sts.is_query)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_mask_reg  <= mahc_pkg::MASK_RESET;
            rom_mask_reg  <= mahc_pkg::MASK_RESET;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ram_mask_reg  <= ram_mask_next;
            rom_mask_reg  <= rom_mask_next;
            sweep_cnt_reg <= sweep_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.update && sts.is_query)
        begin
            out_data_reg <= result;
        end
    end

    always_comb
    begin
        sts.is_hit     = item_reg.func == mahc_pkg::FUNC_HIT;
        sts.is_query   = item_reg.func == mahc_pkg::FUNC_QUERY;
        sts.is_clear   = item_reg.func == mahc_pkg::FUNC_CLEAR;
        sts.sweep_last = sweep_cnt_reg == SWEEP_LAST;
        sts.out_busy   = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/core/mahc_ctrl.sv]
`timescale 1ns / 1ps
module mahc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  mahc_pkg::sts_t sts,
    output mahc_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_SWEEP  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (sts.is_clear)
                begin
                    state_next = ST_SWEEP;
                end
                else if (sts.is_hit || sts.is_query)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UPDATE:
            begin
                // hold a query until the output register frees up
                if (!(sts.is_query && sts.out_busy))
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = state_reg != ST_IDLE;

endmodule

[rtl/core/memory_access_heat_counter.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     in_data  (func, bank_sel, phys_addr, kind)
// out      output     out_valid / out_stall   out_data (read/write/exec_count, cell_valid)
// cfg      input      cfg_we                  cfg_index, cfg_data
//
// A hit or query steps through accept, counter RAM read, read-modify-write or answer.
// A query waits in its last cycle while the previous answer is still held by out_stall.
// A clear steps through accept and lookup, then sweeps max(RAM_CELLS, ROM_CELLS) cells.
// After reset the same sweep zeroes both stores; in_stall stays high meanwhile.
// in_stall stays high until the current transaction is done: one is handled at a time.
module memory_access_heat_counter #(
    parameter int RAM_CELLS   = 65536,
    parameter int ROM_CELLS   = 65536,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mahc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mahc_pkg::MASK_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  mahc_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output mahc_pkg::out_item_t            out_data
);

    mahc_pkg::cmd_t cmd;
    mahc_pkg::sts_t sts;

    mahc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    mahc_dp #(
        .RAM_CELLS   (RAM_CELLS),
        .ROM_CELLS   (ROM_CELLS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // the store sweep runs right after reset
    a_sweep_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> in_stall)
        else $error("input taken before reset sweep");

    // one transaction at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transaction accepted while busy");

    // a new answer only comes from an update of a query
    a_answer_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.update && sts.is_query))
        else $error("answer without query");

    // sweep writes never mix with updates or reads
    a_sweep_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep |-> (!cmd.update && !cmd.lookup && in_stall))
        else $error("sweep overlaps item work");

endmodule
